// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while dis is true.
`define DTP_ASSERT_NOW(lbl, clk, dis, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while dis is true.
`define DTP_ASSERT_NEXT(lbl, clk, dis, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/dtp_pkg.sv =====
// Package with shared types, constants and tables of the duration text parser.
package dtp_pkg;

  localparam int unsigned WHOLE_W  = 64;
  localparam int unsigned FRAC_W   = 30;
  localparam int unsigned MULT_W   = 17;
  localparam int unsigned SECS_W   = 35;
  localparam int unsigned NANO_W   = 30;
  localparam int unsigned WEIGHT_W = 27;
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  localparam logic [29:0] NANO_PER_SEC = 30'd1000000000;

  localparam logic [MULT_W-1:0] MULT_S = 17'd1;
  localparam logic [MULT_W-1:0] MULT_M = 17'd60;
  localparam logic [MULT_W-1:0] MULT_H = 17'd3600;
  localparam logic [MULT_W-1:0] MULT_D = 17'd86400;

  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_DOT = 8'h2e;
  localparam logic [7:0] CH_S   = 8'h73;
  localparam logic [7:0] CH_M   = 8'h6d;
  localparam logic [7:0] CH_H   = 8'h68;
  localparam logic [7:0] CH_D   = 8'h64;
  localparam logic [7:0] CH_0   = 8'h30;
  localparam logic [7:0] CH_9   = 8'h39;

  // Number of significant fraction digits.
  localparam logic [3:0] FRAC_DIGITS = 4'd9;

  // One parsed string handed from the front to the back.
  typedef struct packed {
    logic              ok;
    logic [WHOLE_W-1:0] whole;
    logic [FRAC_W-1:0]  frac;
    logic [MULT_W-1:0]  mult;
  } dtp_rec_t;

  typedef struct packed {
    logic empty;
    logic full;
  } dtp_qstat_t;

  // Nanosecond weight of the fraction digit at position idx (0 = tenths).
  function automatic logic [WEIGHT_W-1:0] frac_weight(input logic [3:0] idx);
    logic [WEIGHT_W-1:0] w;
    case (idx)
      4'd0:    w = 27'd100000000;
      4'd1:    w = 27'd10000000;
      4'd2:    w = 27'd1000000;
      4'd3:    w = 27'd100000;
      4'd4:    w = 27'd10000;
      4'd5:    w = 27'd1000;
      4'd6:    w = 27'd100;
      4'd7:    w = 27'd10;
      4'd8:    w = 27'd1;
      default: w = 27'd0;
    endcase
    return w;
  endfunction

endpackage

// ===== hw/rtl/duration_text_parser.sv =====
// Top level of the duration text parser: front end, record queue and back end.
//
//   channel   direction  handshake          word
//   in_       input      in_push / in_full   one text byte (in_character)
//   out_      output     out_pop / out_empty one duration (valid, seconds, nanoseconds)
//
// Cycles: one character is taken every cycle while in_full is low. A zero byte
// closes the string; with the back end idle its record passes the queue, then
// the back end runs the bit-serial multiplier (30 + 17 steps), the reciprocal
// multiply (4 partial products) and the remainder step before the result
// register. A malformed string skips them.
// Reset: synchronous on rst_n; clears the parser, the queue and the result slot.
// Stalls: in_full rises while the record queue is full; a result waiting on
// out_pop holds the back end only when the next one is finished.
module duration_text_parser #(
  parameter int unsigned QUEUE_DEPTH = dtp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  input  logic [7:0]  in_character,
  output logic        in_full,
  input  logic        out_pop,
  output logic        out_empty,
  output logic        out_valid_time,
  output logic [34:0] out_whole_seconds,
  output logic [29:0] out_nano_part
);
  import dtp_pkg::*;

  logic       in_accept;
  logic       rec_push;
  dtp_rec_t   rec_front;
  dtp_rec_t   rec_head;
  dtp_qstat_t qstat;
  logic       q_pop;

  // Hold input off only while the queue cannot take a finished string.
  assign in_full   = qstat.full;
  assign in_accept = in_push && !in_full;

  dtp_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept_i    (in_accept),
    .character_i (in_character),
    .rec_push_o  (rec_push),
    .rec_o       (rec_front)
  );

  // Decouple parsing from the long arithmetic of the back end.
  dtp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push_i (rec_push),
    .rec_i  (rec_front),
    .pop_i  (q_pop),
    .rec_o  (rec_head),
    .stat_o (qstat)
  );

  dtp_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .rec_i               (rec_head),
    .qstat_i             (qstat),
    .q_pop_o             (q_pop),
    .out_pop_i           (out_pop),
    .out_empty_o         (out_empty),
    .out_valid_time_o    (out_valid_time),
    .out_whole_seconds_o (out_whole_seconds),
    .out_nano_part_o     (out_nano_part)
  );

endmodule

// ===== hw/rtl/dtp_front.sv =====
// Front end: classifies characters and builds the parsed record of one string.
module dtp_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept_i,
  input  logic [7:0]        character_i,
  output logic              rec_push_o,
  output dtp_pkg::dtp_rec_t rec_o
);
  import dtp_pkg::*;

  localparam logic [1:0] PH_WHOLE = 2'd0;
  localparam logic [1:0] PH_FRAC  = 2'd1;
  localparam logic [1:0] PH_AFTER = 2'd2;

  logic [WHOLE_W-1:0] whole_r, whole_nxt;
  logic [FRAC_W-1:0]  frac_r, frac_nxt;
  logic [3:0]         fidx_r, fidx_nxt;
  logic [MULT_W-1:0]  mult_r, mult_nxt;
  logic [1:0]         phase_r, phase_nxt;
  logic               seen_r, seen_nxt;
  logic               bad_r, bad_nxt;

  logic               is_digit;
  logic               is_unit;
  logic [3:0]         digit;
  logic [MULT_W-1:0]  unit_mult;
  logic [30:0]        frac_prod;

  assign digit     = 4'(character_i - CH_0);
  assign is_digit  = character_i inside {[CH_0:CH_9]};
  assign frac_prod = 31'(digit) * 31'(frac_weight(fidx_r));

  always_comb begin
    is_unit   = 1'b1;
    unit_mult = MULT_S;
    case (character_i)
      CH_S:    unit_mult = MULT_S;
      CH_M:    unit_mult = MULT_M;
      CH_H:    unit_mult = MULT_H;
      CH_D:    unit_mult = MULT_D;
      default: is_unit = 1'b0;
    endcase
  end

  assign rec_push_o = accept_i && (character_i == CH_NUL);
  assign rec_o      = '{ok: seen_r && !bad_r, whole: whole_r, frac: frac_r, mult: mult_r};

  always_comb begin
    whole_nxt = whole_r;
    frac_nxt  = frac_r;
    fidx_nxt  = fidx_r;
    mult_nxt  = mult_r;
    phase_nxt = phase_r;
    seen_nxt  = seen_r;
    bad_nxt   = bad_r;
    if (accept_i) begin
      if (character_i == CH_NUL) begin
        // clear for the next string
        whole_nxt = '0;
        frac_nxt  = '0;
        fidx_nxt  = '0;
        mult_nxt  = MULT_S;
        phase_nxt = PH_WHOLE;
        seen_nxt  = 1'b0;
        bad_nxt   = 1'b0;
      end else if (!bad_r) begin
        case (phase_r)
          PH_WHOLE: begin
            if (is_digit) begin
              whole_nxt = {whole_r[WHOLE_W-4:0], 3'b000} + {whole_r[WHOLE_W-2:0], 1'b0}
                          + WHOLE_W'(digit);
              seen_nxt  = 1'b1;
            end else if (character_i == CH_DOT) begin
              phase_nxt = PH_FRAC;
            end else if (is_unit) begin
              mult_nxt  = unit_mult;
              phase_nxt = PH_AFTER;
            end else begin
              bad_nxt = 1'b1;
            end
          end
          PH_FRAC: begin
            if (is_digit) begin
              // digits past the ninth carry zero weight: drop them
              if (fidx_r < FRAC_DIGITS) begin
                frac_nxt = frac_r + FRAC_W'(frac_prod);
                fidx_nxt = fidx_r + 4'd1;
              end
              seen_nxt = 1'b1;
            end else if (is_unit) begin
              mult_nxt  = unit_mult;
              phase_nxt = PH_AFTER;
            end else begin
              bad_nxt = 1'b1;
            end
          end
          default: bad_nxt = 1'b1;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      whole_r <= '0;
      frac_r  <= '0;
      fidx_r  <= '0;
      mult_r  <= MULT_S;
      phase_r <= PH_WHOLE;
      seen_r  <= 1'b0;
      bad_r   <= 1'b0;
    end else begin
      whole_r <= whole_nxt;
      frac_r  <= frac_nxt;
      fidx_r  <= fidx_nxt;
      mult_r  <= mult_nxt;
      phase_r <= phase_nxt;
      seen_r  <= seen_nxt;
      bad_r   <= bad_nxt;
    end
  end

endmodule

// ===== hw/rtl/dtp_queue.sv =====
// Short record queue between the front end and the back end.
module dtp_queue #(
  parameter int unsigned DEPTH = dtp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push_i,
  input  dtp_pkg::dtp_rec_t   rec_i,
  input  logic                pop_i,
  output dtp_pkg::dtp_rec_t   rec_o,
  output dtp_pkg::dtp_qstat_t stat_o
);
  import dtp_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  dtp_rec_t        mem_r [DEPTH];
  logic [PW-1:0]   wptr_r, wptr_nxt;
  logic [PW-1:0]   rptr_r, rptr_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            do_push, do_pop;

  assign stat_o.empty = (cnt_r == '0);
  assign stat_o.full  = (cnt_r == CW'(DEPTH));
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign rec_o        = mem_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == PW'(DEPTH - 1)) ? '0 : wptr_r + PW'(1);
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == PW'(DEPTH - 1)) ? '0 : rptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= rec_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

// ===== hw/rtl/dtp_back.sv =====
// Back end: serial scaling multiply, reciprocal divide by 1e9 and the result register.
module dtp_back (
  input  logic                clk,
  input  logic                rst_n,
  input  dtp_pkg::dtp_rec_t   rec_i,
  input  dtp_pkg::dtp_qstat_t qstat_i,
  output logic                q_pop_o,
  input  logic                out_pop_i,
  output logic                out_empty_o,
  output logic                out_valid_time_o,
  output logic [34:0]         out_whole_seconds_o,
  output logic [29:0]         out_nano_part_o
);
  import dtp_pkg::*;

  localparam logic [2:0] B_IDLE = 3'd0;
  localparam logic [2:0] B_MULA = 3'd1;
  localparam logic [2:0] B_MULB = 3'd2;
  localparam logic [2:0] B_RCP  = 3'd3;
  localparam logic [2:0] B_REM  = 3'd4;
  localparam logic [2:0] B_DONE = 3'd5;

  localparam logic [5:0] MULA_LAST = 6'(FRAC_W - 1);
  localparam logic [5:0] MULB_LAST = 6'(MULT_W - 1);
  localparam logic [5:0] RCP_LAST  = 6'd3;

  // total / 1e9 = (total >> 9) / 5^9; the reciprocal of 5^9 scaled by 2^75 and
  // rounded up gives the exact quotient for any 55-bit dividend.
  localparam logic [20:0] NANO_ODD  = 21'd1953125;
  localparam int unsigned RCP_SHIFT = 75;
  localparam int unsigned PROD_W    = 110;
  localparam logic [75:0] RCP_NUM   = 76'd1 << RCP_SHIFT;
  localparam logic [54:0] RCP_M     = 55'((RCP_NUM / 76'(NANO_ODD)) + 76'd1);

  logic [2:0]         state_r, state_nxt;
  logic [5:0]         cnt_r, cnt_nxt;
  logic [WHOLE_W-1:0] acc_r, acc_nxt;
  logic [WHOLE_W-1:0] mcand_r, mcand_nxt;
  logic [FRAC_W-1:0]  mplier_r, mplier_nxt;
  logic [MULT_W-1:0]  mult_r, mult_nxt;
  logic               ok_r, ok_nxt;
  logic [NANO_W-1:0]  rem_r, rem_nxt;
  logic [PROD_W-1:0]  prod_r, prod_nxt;
  logic               outv_r, outv_nxt;
  logic               res_ok_r;
  logic [SECS_W-1:0]  res_secs_r;
  logic [NANO_W-1:0]  res_nano_r;

  logic [WHOLE_W-1:0] acc_sum;
  logic [54:0]        dvd;
  logic [27:0]        op_a;
  logic [27:0]        op_b;
  logic [55:0]        pp;
  logic [PROD_W-1:0]  pp_shift;
  logic [SECS_W-1:0]  quot;
  logic [NANO_W-1:0]  quot_ns;
  logic               slot_free;
  logic               load_out;

  assign acc_sum   = mplier_r[0] ? acc_r + mcand_r : acc_r;
  assign slot_free = !outv_r || out_pop_i;
  assign load_out  = (state_r == B_DONE) && slot_free;
  assign q_pop_o   = (state_r == B_IDLE) && !qstat_i.empty;

  // One 28x28 partial product of (total >> 9) * RCP_M per cycle.
  assign dvd  = acc_r[WHOLE_W-1:9];
  assign op_a = cnt_r[1] ? {1'b0, dvd[54:28]} : dvd[27:0];
  assign op_b = cnt_r[0] ? {1'b0, RCP_M[54:28]} : RCP_M[27:0];
  assign pp   = 56'(op_a) * 56'(op_b);

  always_comb begin
    case (cnt_r[1:0])
      2'd0:    pp_shift = PROD_W'(pp);
      2'd3:    pp_shift = PROD_W'(pp) << 56;
      default: pp_shift = PROD_W'(pp) << 28;
    endcase
  end

  assign quot    = prod_r[PROD_W-1:RCP_SHIFT];
  assign quot_ns = quot[NANO_W-1:0] * NANO_PER_SEC;

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    acc_nxt    = acc_r;
    mcand_nxt  = mcand_r;
    mplier_nxt = mplier_r;
    mult_nxt   = mult_r;
    ok_nxt     = ok_r;
    rem_nxt    = rem_r;
    prod_nxt   = prod_r;
    outv_nxt   = outv_r;
    if (out_pop_i && outv_r) begin
      outv_nxt = 1'b0;
    end
    case (state_r)
      B_IDLE: begin
        if (!qstat_i.empty) begin
          ok_nxt = rec_i.ok;
          cnt_nxt = '0;
          rem_nxt = '0;
          if (rec_i.ok) begin
            // whole*1e9 + frac first, then scale by the unit
            acc_nxt    = WHOLE_W'(rec_i.frac);
            mcand_nxt  = rec_i.whole;
            mplier_nxt = NANO_PER_SEC;
            mult_nxt   = rec_i.mult;
            state_nxt  = B_MULA;
          end else begin
            acc_nxt   = '0;
            state_nxt = B_DONE;
          end
        end
      end
      B_MULA: begin
        mcand_nxt  = {mcand_r[WHOLE_W-2:0], 1'b0};
        mplier_nxt = {1'b0, mplier_r[FRAC_W-1:1]};
        acc_nxt    = acc_sum;
        cnt_nxt    = cnt_r + 6'd1;
        if (cnt_r == MULA_LAST) begin
          mcand_nxt  = acc_sum;
          acc_nxt    = '0;
          mplier_nxt = FRAC_W'(mult_r);
          cnt_nxt    = '0;
          state_nxt  = B_MULB;
        end
      end
      B_MULB: begin
        mcand_nxt  = {mcand_r[WHOLE_W-2:0], 1'b0};
        mplier_nxt = {1'b0, mplier_r[FRAC_W-1:1]};
        acc_nxt    = acc_sum;
        cnt_nxt    = cnt_r + 6'd1;
        if (cnt_r == MULB_LAST) begin
          cnt_nxt   = '0;
          prod_nxt  = '0;
          state_nxt = B_RCP;
        end
      end
      B_RCP: begin
        // hold the total in acc, accumulate the reciprocal product
        prod_nxt = prod_r + pp_shift;
        cnt_nxt  = cnt_r + 6'd1;
        if (cnt_r == RCP_LAST) begin
          cnt_nxt   = '0;
          state_nxt = B_REM;
        end
      end
      B_REM: begin
        // remainder is below 1e9, so its low 30 bits are enough
        rem_nxt   = acc_r[NANO_W-1:0] - quot_ns;
        acc_nxt   = WHOLE_W'(quot);
        state_nxt = B_DONE;
      end
      B_DONE: begin
        if (slot_free) begin
          outv_nxt  = 1'b1;
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    acc_r    <= acc_nxt;
    mcand_r  <= mcand_nxt;
    mplier_r <= mplier_nxt;
    mult_r   <= mult_nxt;
    ok_r     <= ok_nxt;
    rem_r    <= rem_nxt;
    prod_r   <= prod_nxt;
    cnt_r    <= cnt_nxt;
    if (load_out) begin
      res_ok_r   <= ok_r;
      res_secs_r <= ok_r ? acc_r[SECS_W-1:0] : '0;
      res_nano_r <= ok_r ? rem_r : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      outv_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      outv_r  <= outv_nxt;
    end
  end

  assign out_empty_o         = !outv_r;
  assign out_valid_time_o    = res_ok_r;
  assign out_whole_seconds_o = res_secs_r;
  assign out_nano_part_o     = res_nano_r;

endmodule

// ===== hw/rtl/dtp_checker.sv =====
// Port-level checker for the duration text parser and its bind.
`include "assert_macros.svh"

module dtp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_push,
  input logic [7:0]  in_character,
  input logic        in_full,
  input logic        out_pop,
  input logic        out_empty,
  input logic        out_valid_time,
  input logic [34:0] out_whole_seconds,
  input logic [29:0] out_nano_part
);
  import dtp_pkg::*;

  `DTP_ASSERT_NEXT(a_reset_empty, clk, 1'b0, !rst_n, out_empty, "result shown after reset")
  `DTP_ASSERT_NOW(a_invalid_zero, clk, !rst_n, !out_empty && !out_valid_time, (out_whole_seconds == '0) && (out_nano_part == '0), "invalid result with nonzero time")
  `DTP_ASSERT_NOW(a_nano_range, clk, !rst_n, !out_empty, out_nano_part < NANO_PER_SEC, "nanoseconds out of range")
  `DTP_ASSERT_NEXT(a_hold_result, clk, !rst_n, !out_empty && !out_pop, !out_empty && $stable(out_valid_time) && $stable(out_whole_seconds) && $stable(out_nano_part), "stalled result changed")

endmodule

bind duration_text_parser dtp_checker u_dtp_checker (.*);

// ===== tb/duration_scoreboard_pkg.sv =====
// Scoreboard class that predicts and checks parsed durations.
`timescale 1ns / 1ps

package duration_scoreboard_pkg;
  import dtp_pkg::*;

  typedef enum logic [1:0] {
    PH_WHOLE = 2'd0,
    PH_FRAC  = 2'd1,
    PH_AFTER = 2'd2
  } parse_phase_t;

  typedef struct packed {
    logic               ok;
    logic [SECS_W-1:0]  secs;
    logic [NANO_W-1:0]  nanos;
  } duration_t;

  class duration_scoreboard;
    duration_t            expected_durations[$];
    logic [WHOLE_W-1:0]   whole_count;
    logic [FRAC_W-1:0]    frac_nanos;
    logic [WEIGHT_W-1:0]  digit_weight;
    logic [MULT_W-1:0]    unit_mult;
    parse_phase_t         phase;
    bit                   seen_digit;
    bit                   malformed;
    int                   mismatches;
    int                   words_checked;
    int                   chars_noted;

    function new();
      mismatches    = 0;
      words_checked = 0;
      chars_noted   = 0;
      clear_parse();
    endfunction

    function void clear_parse();
      whole_count  = '0;
      frac_nanos   = '0;
      digit_weight = 27'd100000000;
      unit_mult    = MULT_S;
      phase        = PH_WHOLE;
      seen_digit   = 1'b0;
      malformed    = 1'b0;
    endfunction

    function int pending();
      return expected_durations.size();
    endfunction

    // Map a suffix character to its multiplier; return 0 for other bytes.
    function bit suffix_mult(input logic [7:0] ch, output logic [MULT_W-1:0] mult);
      mult = MULT_S;
      case (ch)
        CH_S: mult = MULT_S;
        CH_M: mult = MULT_M;
        CH_H: mult = MULT_H;
        CH_D: mult = MULT_D;
        default: return 1'b0;
      endcase
      return 1'b1;
    endfunction

    // Advance the parse by one accepted byte; queue a duration at the terminator.
    function void note_character(input logic [7:0] ch);
      duration_t          dur;
      logic [63:0]        total;
      logic [MULT_W-1:0]  mult;
      bit                 is_digit;
      is_digit = (ch >= CH_0) && (ch <= CH_9);
      chars_noted++;
      if (ch == CH_NUL) begin
        dur = '0;
        if (seen_digit && !malformed) begin
          total = whole_count * 64'(unit_mult) * 64'(NANO_PER_SEC)
                + 64'(frac_nanos) * 64'(unit_mult);
          dur.ok    = 1'b1;
          dur.secs  = SECS_W'(total / 64'(NANO_PER_SEC));
          dur.nanos = NANO_W'(total % 64'(NANO_PER_SEC));
        end
        expected_durations.push_back(dur);
        clear_parse();
        return;
      end
      if (malformed) return;
      case (phase)
        PH_WHOLE: begin
          if (is_digit) begin
            whole_count = whole_count * 64'd10 + 64'(ch - CH_0);
            seen_digit  = 1'b1;
          end else if (ch == CH_DOT) begin
            phase = PH_FRAC;
          end else if (suffix_mult(ch, mult)) begin
            unit_mult = mult;
            phase     = PH_AFTER;
          end else begin
            malformed = 1'b1;
          end
        end
        PH_FRAC: begin
          if (is_digit) begin
            if (digit_weight != 0) begin
              frac_nanos   = frac_nanos + FRAC_W'(ch - CH_0) * FRAC_W'(digit_weight);
              digit_weight = digit_weight / 27'd10;
            end
            seen_digit = 1'b1;
          end else if (suffix_mult(ch, mult)) begin
            unit_mult = mult;
            phase     = PH_AFTER;
          end else begin
            malformed = 1'b1;
          end
        end
        default: malformed = 1'b1;
      endcase
    endfunction

    task report_mismatch(input string what, input logic [63:0] got, input logic [63:0] want);
      $display("ERROR word %0d %s: got %0d, expected %0d", words_checked, what, got, want);
      mismatches++;
    endtask

    task check_duration(input logic ok, input logic [SECS_W-1:0] secs,
                        input logic [NANO_W-1:0] nanos);
      duration_t want;
      words_checked++;
      if (expected_durations.size() == 0) begin
        report_mismatch("unexpected word, valid_time", 64'(ok), 64'd0);
        return;
      end
      want = expected_durations.pop_front();
      if (ok !== want.ok) report_mismatch("valid_time", 64'(ok), 64'(want.ok));
      if (secs !== want.secs) report_mismatch("whole_seconds", 64'(secs), 64'(want.secs));
      if (nanos !== want.nanos) report_mismatch("nano_part", 64'(nanos), 64'(want.nanos));
    endtask
  endclass

endpackage

// ===== tb/testbench.sv =====
// Top-level testbench of the duration text parser.
`timescale 1ns / 1ps

module testbench;
  import dtp_pkg::*;
  import duration_scoreboard_pkg::*;

  // Cycles with no word moving on either side before the run is declared hung.
  // The slowest legal gap is a back-end pass behind a full queue plus a
  // receiver stall, so this leaves a wide margin.
  localparam int IDLE_LIMIT   = 4000;
  localparam int TARGET_CHARS = 1300;
  localparam int SETTLE_TIME  = 150;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_push = 1'b0;
  logic [7:0]  in_character = 8'h00;
  logic        in_full;
  logic        out_pop = 1'b0;
  logic        out_empty;
  logic        out_valid_time;
  logic [34:0] out_whole_seconds;
  logic [29:0] out_nano_part;

  duration_scoreboard sb = new();

  logic [7:0]  text_buf[$];
  int          burst_left = 0;
  int          idle_cycles = 0;
  int          pop_cycle = 0;

  duration_text_parser DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_character     (in_character),
    .in_full          (in_full),
    .out_pop          (out_pop),
    .out_empty        (out_empty),
    .out_valid_time   (out_valid_time),
    .out_whole_seconds(out_whole_seconds),
    .out_nano_part    (out_nano_part)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver: check each popped word, then pick the next pop from a pattern
  // that cycles through four modes: always ready, random, short periodic
  // stalls and long stalls.
  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty)
      sb.check_duration(out_valid_time, out_whole_seconds, out_nano_part);
    pop_cycle <= pop_cycle + 1;
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      case (pop_cycle[9:8])
        2'd0: out_pop <= 1'b1;
        2'd1: out_pop <= ($urandom_range(0, 3) != 0);
        2'd2: out_pop <= ((pop_cycle % 7) < 3);
        default: out_pop <= (pop_cycle[4:0] >= 5'd26);
      endcase
    end
  end

  // Watchdog: count cycles in which neither side moves a word.
  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // Push one byte. Bursts of random length alternate with random gaps; a gap
  // of zero keeps push high so some stretches run without idling.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      case ($urandom_range(0, 7))
        0, 1: gap = 0;
        7:    gap = $urandom_range(20, 40);
        default: gap = $urandom_range(1, 8);
      endcase
      if (gap != 0) begin
        in_push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 200)
                                               : $urandom_range(1, 24);
    end
    in_push      <= 1'b1;
    in_character <= b;
    // Hold the byte until an edge sees full low.
    do @(posedge clk); while (in_full);
    sb.note_character(b);
    burst_left--;
  endtask

  // Send the buffered text followed by the terminator.
  task automatic send_buffer();
    foreach (text_buf[i]) send_byte(text_buf[i]);
    send_byte(CH_NUL);
  endtask

  task automatic send_text(input string s);
    text_buf.delete();
    for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
    send_buffer();
  endtask

  // Drop push and hold off until every expected word has been popped.
  task automatic drain_results();
    in_push <= 1'b0;
    burst_left = 0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic add_digits(input int count);
    for (int i = 0; i < count; i++)
      text_buf.push_back(CH_0 + 8'($urandom_range(0, 9)));
  endtask

  // Build a well-formed duration with random content. Long whole parts
  // exercise the 64-bit wrap; long fractions run past the ninth digit.
  task automatic build_duration();
    logic [7:0] suffixes[4];
    int         n_whole;
    int         n_frac;
    int         pick;
    bit         with_dot;
    suffixes = '{CH_S, CH_M, CH_H, CH_D};
    text_buf.delete();
    pick = $urandom_range(0, 9);
    if (pick == 0)      n_whole = 0;
    else if (pick <= 6) n_whole = $urandom_range(1, 3);
    else if (pick <= 8) n_whole = $urandom_range(4, 10);
    else                n_whole = $urandom_range(15, 24);
    with_dot = ($urandom_range(0, 1) == 1);
    n_frac = 0;
    if (with_dot)
      n_frac = ($urandom_range(0, 4) == 0) ? $urandom_range(8, 13) : $urandom_range(0, 4);
    // Keep most strings valid by forcing at least one digit.
    if (n_whole == 0 && n_frac == 0 && $urandom_range(0, 7) != 0) n_whole = 1;
    add_digits(n_whole);
    if (with_dot) begin
      text_buf.push_back(CH_DOT);
      add_digits(n_frac);
    end
    pick = $urandom_range(0, 4);
    if (pick != 0) text_buf.push_back(suffixes[pick - 1]);
  endtask

  // Try to break a well-formed string: insert a dot, a suffix or any nonzero byte.
  task automatic corrupt_duration();
    logic [7:0] junk;
    int         pos;
    case ($urandom_range(0, 2))
      0: junk = CH_DOT;
      1: junk = CH_H;
      default: junk = 8'($urandom_range(1, 255));
    endcase
    pos = $urandom_range(0, text_buf.size());
    text_buf.insert(pos, junk);
  endtask

  task automatic build_noise();
    int len;
    text_buf.delete();
    len = $urandom_range(0, 6);
    for (int i = 0; i < len; i++) text_buf.push_back(8'($urandom_range(1, 255)));
  endtask

  initial begin
    int strings_sent;
    int pick;
    strings_sent = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty string, lone dot, lone suffix, second dot, text after
    // the suffix, a stray top byte, then valid strings with fraction and units.
    send_text("");
    send_text(".");
    send_text("h");
    send_text("5.5.");
    send_text("2sx");
    text_buf.delete();
    text_buf.push_back(8'hff);
    send_buffer();
    send_text("9.5d");
    send_text("60m");
    drain_results();

    // Random: mostly well-formed durations, some broken ones and some noise.
    while (sb.chars_noted < TARGET_CHARS) begin
      pick = $urandom_range(0, 9);
      if (pick <= 6) begin
        build_duration();
      end else if (pick <= 8) begin
        build_duration();
        corrupt_duration();
      end else begin
        build_noise();
      end
      send_buffer();
      strings_sent++;
      if (strings_sent % 50 == 0) drain_results();
    end

    drain_results();
    repeat (SETTLE_TIME) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
